### rtl/ssa_pkg.sv
// Shared types, constants and helper functions of the stats slot allocator.
package ssa_pkg;

  // Counter width and the reach of the 7-bit slot field
  localparam int CNT_W      = 64;
  localparam int SLOT_IN_W  = 7;
  localparam int ADDR_LIMIT = 128;

  // Bitmap scan word
  localparam int WORD_W     = 32;
  localparam int BITPOS_W   = $clog2(WORD_W);

  // Stream payload widths
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 200;
  localparam int CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE   = 2'd0,
    CMD_UPDATE    = 2'd1,
    CMD_RELEASE   = 2'd2,
    CMD_AGGREGATE = 2'd3
  } cmd_t;

  // Three counters of one slot
  typedef struct packed {
    logic [CNT_W-1:0] failed;
    logic [CNT_W-1:0] success;
    logic [CNT_W-1:0] total;
  } counters_t;

  // Control of the shared accumulate unit
  typedef struct packed {
    logic load_acc;  // copy historical totals into the accumulator
    logic add_acc;   // accumulator += read counters
    logic add_hist;  // historical totals += read counters
  } acc_ctrl_t;

  // Position of the lowest set bit of one scan word
  function automatic logic [BITPOS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BITPOS_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BITPOS_W'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/ssa_ram.sv
// Slot counter memory: one write port, one registered read port.
module ssa_ram
  import ssa_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  counters_t     wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output counters_t     rdata
);

  counters_t mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ssa_accum.sv
// Shared 64-bit accumulate unit with the historical totals and the aggregate sum.
module ssa_accum
  import ssa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  acc_ctrl_t ctrl,
  input  counters_t data,
  output counters_t acc
);

  counters_t hist;
  counters_t base;
  counters_t sum;

  // One adder per counter, shared by release and aggregate
  always_comb begin
    base        = ctrl.add_hist ? hist : acc;
    sum.total   = base.total + data.total;
    sum.success = base.success + data.success;
    sum.failed  = base.failed + data.failed;
  end

  // Historical totals
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.add_hist) begin
      hist <= sum;
    end
  end

  // Aggregate accumulator
  always_ff @(posedge clk) begin
    if (ctrl.load_acc) begin
      acc <= hist;
    end else if (ctrl.add_acc) begin
      acc <= sum;
    end
  end

endmodule

### rtl/stats_slot_allocator.sv
// Top level of the stats slot allocator: sequencer, free bitmap and stream ports.
//
// Commands arrive on the s_ stream, one transfer per command; cmd travels in
// s_tuser. Every command yields exactly one result transfer on the m_ stream.
// The block works on one command at a time; s_tready is high only while idle.
// An update writes the counter memory as the command is taken. A release of a
// slot in range makes one registered memory read, then folds and clears. An
// acquire scans at most ceil(min(NUM_SLOTS,128)/32) words of the free bitmap,
// one word per cycle. An aggregate makes one counter memory read per slot into
// the shared 64-bit accumulate unit. After reset a clearing pass zeroes the
// counter memory; no command is taken until it ends. Reset also frees every
// slot and zeroes the historical totals. The result sits in an output
// register: a new command is taken while the previous result still waits, and
// a finished result holds inside the block until m_tready frees the output
// register.
module stats_slot_allocator
  import ssa_pkg::*;
#(
  parameter int NUM_SLOTS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // slot[6:0], total_in[70:7], success_in[134:71], failed_in[198:135], zero[199]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[0], slot_out[7:1], total_out[71:8], success_out[135:72], failed_out[199:136]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int SLOT_AW      = $clog2(NUM_SLOTS);
  localparam int SEARCH_SLOTS = (NUM_SLOTS < ADDR_LIMIT) ? NUM_SLOTS : ADDR_LIMIT;
  localparam int NUM_WORDS    = (SEARCH_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PAD_W        = NUM_WORDS * WORD_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_REL    = 7'b0001000,
    ST_AGG    = 7'b0010000,
    ST_TAIL   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [SLOT_AW-1:0]   cnt;
  logic [WIDX_W-1:0]    word_idx;
  logic [SLOT_AW-1:0]   slot_r;
  logic                 res_status;
  logic [SLOT_IN_W-1:0] res_slot;
  logic                 res_agg;
  logic                 act_d;
  logic                 add_pend;
  logic [NUM_SLOTS-1:0] active;

  logic                 accept;
  cmd_t                 in_cmd;
  logic [SLOT_AW-1:0]   in_addr;
  logic                 in_range;
  counters_t            in_data;
  logic [PAD_W-1:0]     busy_pad;
  logic [WORD_W-1:0]    free_word;
  logic                 word_hit;
  logic [WIDX_W+BITPOS_W-1:0] grant_wide;
  logic [SLOT_AW-1:0]   grant;
  logic                 out_load;
  counters_t            out_cnt;

  logic                 ram_we;
  logic [SLOT_AW-1:0]   ram_waddr;
  counters_t            ram_wdata;
  logic                 ram_re;
  logic [SLOT_AW-1:0]   ram_raddr;
  counters_t            ram_rdata;
  acc_ctrl_t            acc_ctrl;
  counters_t            acc;

  // Decode the input transfer
  assign s_tready        = (state == ST_IDLE);
  assign accept          = s_tvalid && s_tready;
  assign in_cmd          = cmd_t'(s_tuser);
  assign in_addr         = SLOT_AW'(s_tdata[SLOT_IN_W-1:0]);
  assign in_range        = (32'(s_tdata[SLOT_IN_W-1:0]) < NUM_SLOTS);
  assign in_data.total   = s_tdata[70:7];
  assign in_data.success = s_tdata[134:71];
  assign in_data.failed  = s_tdata[198:135];

  // Pad the searchable bitmap to whole words; padding reads as busy
  for (genvar i = 0; i < PAD_W; i++) begin : g_pad
    if (i < SEARCH_SLOTS) begin : g_live
      assign busy_pad[i] = active[i];
    end else begin : g_fill
      assign busy_pad[i] = 1'b1;
    end
  end

  // Scan one bitmap word per cycle
  assign free_word  = ~busy_pad[word_idx * WORD_W +: WORD_W];
  assign word_hit   = |free_word;
  assign grant_wide = {word_idx, lowest_set(free_word)};
  assign grant      = SLOT_AW'(grant_wide);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == SLOT_AW'(NUM_SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ACQUIRE:   state_next = ST_SCAN;
            CMD_RELEASE:   state_next = in_range ? ST_REL : ST_FINISH;
            CMD_AGGREGATE: state_next = ST_AGG;
            default:       state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (word_hit || (word_idx == WIDX_W'(NUM_WORDS - 1))) state_next = ST_FINISH;
      end
      ST_REL: begin
        state_next = ST_FINISH;
      end
      ST_AGG: begin
        if (cnt == SLOT_AW'(NUM_SLOTS - 1)) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter for the clearing pass and the aggregate walk
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_CLEAR || state == ST_AGG) begin
      cnt <= (cnt == SLOT_AW'(NUM_SLOTS - 1)) ? '0 : cnt + 1'b1;
    end
  end

  // Scan word index
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx <= '0;
    end else if (accept) begin
      word_idx <= '0;
    end else if (state == ST_SCAN && !word_hit) begin
      word_idx <= word_idx + 1'b1;
    end
  end

  // Hold the slot number and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_status <= 1'b0;
      res_slot   <= '0;
      res_agg    <= 1'b0;
    end else if (accept) begin
      slot_r     <= in_addr;
      res_status <= 1'b0;
      res_slot   <= '0;
      res_agg    <= (in_cmd == CMD_AGGREGATE);
    end else if (state == ST_SCAN) begin
      if (word_hit) begin
        res_slot <= SLOT_IN_W'(grant);
      end else if (word_idx == WIDX_W'(NUM_WORDS - 1)) begin
        res_status <= 1'b1;
      end
    end
  end

  // Free bitmap: set on acquire, clear on release
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (state == ST_SCAN && word_hit) begin
      active[grant] <= 1'b1;
    end else if (state == ST_REL) begin
      active[slot_r] <= 1'b0;
    end
  end

  // Align the active bit with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      add_pend <= 1'b0;
      act_d    <= 1'b0;
    end else begin
      add_pend <= (state == ST_AGG);
      act_d    <= active[cnt];
    end
  end

  // Memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cnt;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && in_range && in_cmd == CMD_UPDATE) begin
          ram_we    = 1'b1;
          ram_waddr = in_addr;
          ram_wdata = in_data;
        end
        if (accept && in_range && in_cmd == CMD_RELEASE) begin
          ram_re    = 1'b1;
          ram_raddr = in_addr;
        end
      end
      ST_SCAN: begin
        ram_we    = word_hit;
        ram_waddr = grant;
      end
      ST_REL: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
      end
      ST_AGG: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ssa_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accumulate unit control
  always_comb begin
    acc_ctrl.load_acc = accept && (in_cmd == CMD_AGGREGATE);
    acc_ctrl.add_acc  = (state == ST_AGG || state == ST_TAIL) && add_pend && act_d;
    acc_ctrl.add_hist = (state == ST_REL);
  end

  ssa_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .ctrl (acc_ctrl),
    .data (ram_rdata),
    .acc  (acc)
  );

  // Output register: load when empty or being drained
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign out_cnt  = res_agg ? acc : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {out_cnt.failed, out_cnt.success, out_cnt.total, res_slot, res_status};
    end
  end

endmodule

### verif/stats_slot_allocator_checker.sv
// Checker for the stats slot allocator: tracks slot state, predicts each result and compares.
module stats_slot_allocator_checker
  import ssa_pkg::*;
#(
  parameter int NUM_SLOTS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // slot[6:0], total_in[70:7], success_in[134:71], failed_in[198:135], zero[199]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // status[0], slot_out[7:1], total_out[71:8], success_out[135:72], failed_out[199:136]
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending
);

  localparam int SEARCH_SLOTS = (NUM_SLOTS < ADDR_LIMIT) ? NUM_SLOTS : ADDR_LIMIT;

  typedef struct packed {
    logic                 status;
    logic [SLOT_IN_W-1:0] grant;
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     success;
    logic [CNT_W-1:0]     failed;
  } slot_result_t;

  // Shadow of the slot bank and the folded-in totals
  logic         slot_active [NUM_SLOTS];
  counters_t    slot_counts [NUM_SLOTS];
  counters_t    folded_totals;
  slot_result_t awaited_results [$];

  // Apply one command to the shadow state and return the result it produces
  function automatic slot_result_t apply_command(input cmd_t cmd,
                                                 input logic [SLOT_IN_W-1:0] slot,
                                                 input counters_t wr);
    slot_result_t res;
    counters_t    acc;
    logic         found;
    res   = '0;
    found = 1'b0;
    case (cmd)
      CMD_ACQUIRE: begin
        for (int i = 0; i < SEARCH_SLOTS; i++) begin
          if (!found && !slot_active[i]) begin
            found          = 1'b1;
            slot_active[i] = 1'b1;
            slot_counts[i] = '0;
            res.grant      = SLOT_IN_W'(i);
          end
        end
        res.status = !found;
      end
      CMD_UPDATE: begin
        if (int'(slot) < NUM_SLOTS) slot_counts[slot] = wr;
      end
      CMD_RELEASE: begin
        if (int'(slot) < NUM_SLOTS) begin
          folded_totals.total   = folded_totals.total   + slot_counts[slot].total;
          folded_totals.success = folded_totals.success + slot_counts[slot].success;
          folded_totals.failed  = folded_totals.failed  + slot_counts[slot].failed;
          slot_counts[slot]     = '0;
          slot_active[slot]     = 1'b0;
        end
      end
      default: begin
        acc = folded_totals;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_active[i]) begin
            acc.total   = acc.total   + slot_counts[i].total;
            acc.success = acc.success + slot_counts[i].success;
            acc.failed  = acc.failed  + slot_counts[i].failed;
          end
        end
        res.total   = acc.total;
        res.success = acc.success;
        res.failed  = acc.failed;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_active[i] = 1'b0;
        slot_counts[i] = '0;
      end
      folded_totals = '0;
      awaited_results.delete();
      errors = 0;
    end else begin
      // Compare a result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.status  = m_tdata[0];
        got.grant   = m_tdata[7:1];
        got.total   = m_tdata[71:8];
        got.success = m_tdata[135:72];
        got.failed  = m_tdata[199:136];
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing outstanding: 0x%0h", m_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(got.status));
          check_field("slot_out", CNT_W'(want.grant), CNT_W'(got.grant));
          check_field("total_out", want.total, got.total);
          check_field("success_out", want.success, got.success);
          check_field("failed_out", want.failed, got.failed);
        end
      end
      // Predict the result of a command transfer
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_command(cmd_t'(s_tuser), s_tdata[6:0],
                                                counters_t'(s_tdata[198:7])));
      end
    end
    pending = awaited_results.size();
  end

endmodule

### verif/stats_slot_allocator_tb.sv
// Testbench top for the stats slot allocator: stimulus, flow control, watchdog and verdict.
module stats_slot_allocator_tb
  import ssa_pkg::*;
;

  localparam int NUM_SLOTS    = 128;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES       = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 20;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors;
  int                    pending;

  int idle_pct;
  int stall_pct;
  int acquire_pct;
  int quiet_cycles;
  int issued [4];
  int full_hits;
  // Stimulus-side view of which slots are held, used to aim updates and releases
  logic [NUM_SLOTS-1:0] held;

  stats_slot_allocator #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stats_slot_allocator_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Counter values biased toward the edges of the 64-bit range
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom_range(255));
      3:       return {1'b1, 63'($urandom_range(15))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic counters_t pick_counters();
    counters_t c;
    c.total   = pick_count();
    c.success = pick_count();
    c.failed  = pick_count();
    return c;
  endfunction

  // Mostly a held slot, otherwise any slot the field can name
  function automatic logic [SLOT_IN_W-1:0] pick_slot();
    int start;
    start = $urandom_range(NUM_SLOTS - 1);
    if (held != '0 && $urandom_range(99) < 75) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (held[(start + k) % NUM_SLOTS]) return SLOT_IN_W'((start + k) % NUM_SLOTS);
      end
    end
    return SLOT_IN_W'($urandom_range(127));
  endfunction

  // Present one command, hold it until the transfer, then track the bitmap
  task automatic issue(input cmd_t cmd, input logic [SLOT_IN_W-1:0] slot,
                       input counters_t cnt);
    logic granted;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, cnt, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    issued[int'(cmd)]++;
    granted = 1'b0;
    case (cmd)
      CMD_ACQUIRE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!granted && !held[i]) begin
            held[i] = 1'b1;
            granted = 1'b1;
          end
        end
        if (!granted) full_hits++;
      end
      CMD_RELEASE: held[slot] = 1'b0;
      default: ;
    endcase
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < acquire_pct) issue(CMD_ACQUIRE, SLOT_IN_W'($urandom), pick_counters());
    else if (r < acquire_pct + 38) issue(CMD_UPDATE, pick_slot(), pick_counters());
    else if (r < 94) issue(CMD_RELEASE, pick_slot(), pick_counters());
    else issue(CMD_AGGREGATE, SLOT_IN_W'($urandom), pick_counters());
  endtask

  initial begin
    counters_t ones;
    counters_t stripes;
    counters_t none;
    int        per_phase;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_ACQUIRE;
    idle_pct     = 0;
    stall_pct    = 0;
    acquire_pct  = 30;
    full_hits    = 0;
    held         = '0;
    for (int i = 0; i < 4; i++) issued[i] = 0;
    ones    = '1;
    none    = '0;
    stripes = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty totals, wrap of sums, free-slot update and release
    issue(CMD_AGGREGATE, 7'h7F, ones);
    issue(CMD_ACQUIRE, 7'h7F, ones);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_ACQUIRE, 7'h2A, stripes);
    issue(CMD_UPDATE, 7'd0, ones);
    issue(CMD_UPDATE, 7'd1, ones);
    issue(CMD_UPDATE, 7'd2, stripes);
    issue(CMD_AGGREGATE, 7'h00, none);
    issue(CMD_UPDATE, 7'd127, ones);
    issue(CMD_AGGREGATE, 7'h55, stripes);
    issue(CMD_RELEASE, 7'd1, none);
    issue(CMD_AGGREGATE, 7'h00, none);
    issue(CMD_RELEASE, 7'd127, none);
    issue(CMD_AGGREGATE, 7'h00, none);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_AGGREGATE, 7'h00, none);
    issue(CMD_UPDATE, 7'd1, stripes);
    issue(CMD_RELEASE, 7'd0, ones);
    issue(CMD_RELEASE, 7'd2, none);
    issue(CMD_RELEASE, 7'd127, none);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_AGGREGATE, 7'h00, none);
    drain();

    // Fill the bank, then acquire past full
    while (held != '1) issue(CMD_ACQUIRE, SLOT_IN_W'($urandom), none);
    issue(CMD_UPDATE, 7'd127, ones);
    issue(CMD_UPDATE, 7'd64, stripes);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_ACQUIRE, 7'h7F, ones);
    issue(CMD_AGGREGATE, 7'h00, none);
    issue(CMD_RELEASE, 7'd64, none);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_ACQUIRE, 7'h00, none);
    issue(CMD_AGGREGATE, 7'h00, none);
    drain();

    // Random phases over the idle/stall mixes and two command mixes
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      acquire_pct = (p < PHASES / 2) ? 30 : 50;
      for (int n = 0; n < per_phase; n++) begin
        random_item();
        if ($urandom_range(59) == 0) drain();
      end
      drain();
    end

    // Wait out the tail, then give the verdict
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d acquires (%0d with the bank full), %0d updates, %0d releases,",
             issued[CMD_ACQUIRE], full_hits, issued[CMD_UPDATE], issued[CMD_RELEASE]);
    $display("%0d aggregates, under sender gaps and receiver stalls of 0, 38 and 55 percent",
             issued[CMD_AGGREGATE]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
